### src/scale_weight_frame_decoder_core_macros.svh
// Assertion macros shared by the scale weight frame decoder.
`ifndef SCALE_WEIGHT_FRAME_DECODER_CORE_MACROS_SVH
`define SCALE_WEIGHT_FRAME_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWFD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swfd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SWFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swfd assertion failed");

`endif

### src/swfd_pkg.sv
// Types, constants and helper functions of the scale weight frame decoder.
`timescale 1ns / 1ps

package swfd_pkg;

    localparam int DIGIT_COUNT_DEF = 6;
    localparam int BYTE_W          = 8;
    localparam int FRAME_LEN_W     = 7;
    localparam int CODE_W          = 3;
    localparam int WEIGHT_W        = 37;
    localparam int FIRST_DIGIT_POS = 4;
    localparam int BASE_SHIFT      = 5;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 7'd18;
    localparam logic [FRAME_LEN_W-1:0] COUNT_MAX       = 7'd127;
    localparam logic [BYTE_W-1:0]      STX_BYTE        = 8'h02;
    localparam logic [BYTE_W-1:0]      ASCII_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0]      ASCII_NINE      = 8'h39;
    localparam logic [CODE_W-1:0]      CODE_PLAIN_MAX  = 3'd2;
    localparam logic [CODE_W-1:0]      CODE_SHIFT_REF  = 3'd7;

    // Bits needed to hold 10^n - 1.
    function automatic int acc_width(input int n);
        longint unsigned v;
        v = 1;
        for (int i = 0; i < n; i++) begin
            v = v * 10;
        end
        return $clog2(v);
    endfunction

    // 10^e, clamped to 2^WEIGHT_W so that any nonzero multiple of it saturates.
    function automatic logic [WEIGHT_W:0] pow10_clamp(input int e);
        longint unsigned v;
        longint unsigned lim;
        v   = 1;
        lim = longint'(1) << WEIGHT_W;
        for (int i = 0; i < e; i++) begin
            v = v * 10;
            if (v > lim) begin
                v = lim;
            end
        end
        return v[WEIGHT_W:0];
    endfunction

endpackage

### src/swfd_channels_if.sv
// Handshake channel interfaces of the scale weight frame decoder.
`timescale 1ns / 1ps

interface swfd_cfg_if
    import swfd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [FRAME_LEN_W-1:0] frame_length;

    modport source (output valid, output frame_length, input ready);
    modport sink   (input valid, input frame_length, output ready);
endinterface

interface swfd_in_if
    import swfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swfd_out_if
    import swfd_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] weight_scaled;
    logic [CODE_W-1:0]   decimal_code;

    modport source (output valid, output weight_scaled, output decimal_code, input ready);
    modport sink   (input valid, input weight_scaled, input decimal_code, output ready);
endinterface

### src/scale_weight_frame_decoder_core.sv
// Scale weight frame decoder: frame tracking, digit folding and weight scaling.
//
//  channel | port  | dir | payload
//  --------+-------+-----+------------------------------------
//  config  | i_cfg | in  | frame_length (7 bits)
//  bytes   | i_in  | in  | rx_byte (8 bits)
//  weights | o_out | out | weight_scaled (37 bits), decimal_code (3 bits)
//
// One byte is taken per cycle while i_in is ready; frame state updates on the
// accepting edge. A finished frame passes a scale stage and an output register;
// the scale stage holds one multiplier. Reset (synchronous, active low) returns
// to waiting for STX, frame length 18. A stalled output holds both stages;
// bytes are refused only while both are full. Configuration writes are always
// taken.
`timescale 1ns / 1ps
`include "scale_weight_frame_decoder_core_macros.svh"

module scale_weight_frame_decoder_core
    import swfd_pkg::*;
#(
    parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swfd_cfg_if.sink    i_cfg,
    swfd_in_if.sink     i_in,
    swfd_out_if.source  o_out
);

    localparam int ACC_W  = acc_width(DIGIT_COUNT);
    localparam int EXP_N  = DIGIT_COUNT + BASE_SHIFT + 1;
    localparam int EXP_W  = $clog2(EXP_N);
    localparam int SEEN_W = $clog2(DIGIT_COUNT + 1);
    localparam int PROD_W = ACC_W + WEIGHT_W + 1;

    localparam logic [ACC_W-1:0]       ACC_MAX   = ACC_W'(pow10_clamp(DIGIT_COUNT) - 1);
    localparam logic [FRAME_LEN_W-1:0] FIRST_POS = FRAME_LEN_W'(FIRST_DIGIT_POS);
    localparam logic [FRAME_LEN_W-1:0] LAST_POS  =
        FRAME_LEN_W'(FIRST_DIGIT_POS + DIGIT_COUNT);
    localparam logic [FRAME_LEN_W-1:0] DIGITS_7  = FRAME_LEN_W'(DIGIT_COUNT);

    logic [FRAME_LEN_W-1:0] r_frame_len;
    logic                   r_in_frame, n_in_frame;
    logic [FRAME_LEN_W-1:0] r_count, n_count;
    logic [CODE_W-1:0]      r_code, n_code;
    logic [ACC_W-1:0]       r_acc, n_acc;

    logic                   r_fin_valid;
    logic [ACC_W-1:0]       r_fin_acc;
    logic [EXP_W-1:0]       r_fin_exp;
    logic [CODE_W-1:0]      r_fin_code;

    logic                   r_out_valid;
    logic [WEIGHT_W-1:0]    r_out_weight;
    logic [CODE_W-1:0]      r_out_code;

    logic                   w_out_adv, w_fin_adv, w_in_acc;
    logic                   w_finish, w_is_digit;
    logic [3:0]             w_dig;
    logic [FRAME_LEN_W-1:0] w_cnt_new, w_seen_raw;
    logic [SEEN_W-1:0]      w_seen;
    logic [CODE_W-1:0]      w_shift;
    logic [EXP_W-1:0]       w_exp;
    logic [WEIGHT_W:0]      w_pow_tab [EXP_N];
    logic [PROD_W-1:0]      w_prod;
    logic [WEIGHT_W-1:0]    w_weight;

    for (genvar k = 0; k < EXP_N; k++) begin : g_pow
        assign w_pow_tab[k] = pow10_clamp(k);
    end

    assign w_out_adv = !r_out_valid || o_out.ready;
    assign w_fin_adv = !r_fin_valid || w_out_adv;
    assign w_in_acc  = i_in.valid && w_fin_adv;

    assign i_in.ready          = w_fin_adv;
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.weight_scaled = r_out_weight;
    assign o_out.decimal_code  = r_out_code;

    assign w_is_digit = (i_in.rx_byte >= ASCII_ZERO) && (i_in.rx_byte <= ASCII_NINE);
    assign w_dig      = w_is_digit ? 4'(i_in.rx_byte - ASCII_ZERO) : 4'd0;

    always_comb begin
        n_in_frame = r_in_frame;
        n_code     = r_code;
        n_acc      = r_acc;
        w_cnt_new  = r_count;
        w_finish   = 1'b0;
        if (!r_in_frame) begin
            if (i_in.rx_byte == STX_BYTE) begin
                n_in_frame = 1'b1;
                w_cnt_new  = 7'd1;
                n_code     = '0;
                n_acc      = '0;
                w_finish   = (r_frame_len <= 7'd1);
            end
        end else begin
            if (r_count == 7'd1) begin
                n_code = i_in.rx_byte[CODE_W-1:0];
            end
            if (r_count >= FIRST_POS && r_count < LAST_POS) begin
                n_acc = ACC_W'({r_acc, 3'b000} + {r_acc, 1'b0} + w_dig);
            end
            if (r_count != COUNT_MAX) begin
                w_cnt_new = r_count + 7'd1;
            end
            w_finish = (w_cnt_new >= r_frame_len);
        end
        n_count = w_cnt_new;
        if (w_finish) begin
            n_in_frame = 1'b0;
            n_count    = '0;
        end
    end

    // Digit positions that never arrived count as trailing zeros.
    always_comb begin
        w_seen_raw = (w_cnt_new > FIRST_POS) ? (w_cnt_new - FIRST_POS) : '0;
        w_seen     = (w_seen_raw > DIGITS_7) ? SEEN_W'(DIGIT_COUNT)
                                             : w_seen_raw[SEEN_W-1:0];
        w_shift    = (n_code <= CODE_PLAIN_MAX) ? CODE_W'(BASE_SHIFT)
                                                : (CODE_SHIFT_REF - n_code);
        w_exp      = EXP_W'(DIGIT_COUNT) - EXP_W'(w_seen) + EXP_W'(w_shift);
    end

    assign w_prod   = {{(WEIGHT_W + 1){1'b0}}, r_fin_acc} * {{ACC_W{1'b0}}, w_pow_tab[r_fin_exp]};
    assign w_weight = (|w_prod[PROD_W-1:WEIGHT_W]) ? {WEIGHT_W{1'b1}} : w_prod[WEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RESET;
            r_in_frame  <= 1'b0;
            r_count     <= '0;
            r_code      <= '0;
            r_acc       <= '0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_frame_len <= i_cfg.frame_length;
            end
            if (w_in_acc) begin
                r_in_frame <= n_in_frame;
                r_count    <= n_count;
                r_code     <= n_code;
                r_acc      <= n_acc;
            end
            if (w_fin_adv) begin
                r_fin_valid <= w_in_acc && w_finish;
            end
            if (w_out_adv) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_finish) begin
            r_fin_acc  <= n_acc;
            r_fin_exp  <= w_exp;
            r_fin_code <= n_code;
        end
        if (w_out_adv && r_fin_valid) begin
            r_out_weight <= w_weight;
            r_out_code   <= r_fin_code;
        end
    end

    `SWFD_ASSERT_SAME(a_idle_count_zero, !r_in_frame, r_count == '0)
    `SWFD_ASSERT_SAME(a_frame_count_live, r_in_frame, r_count != '0)
    `SWFD_ASSERT_SAME(a_acc_range, 1'b1, r_acc <= ACC_MAX)
    `SWFD_ASSERT_NEXT(a_idle_drop, w_in_acc && !r_in_frame && i_in.rx_byte != STX_BYTE, !r_fin_valid)
    `SWFD_ASSERT_NEXT(a_zero_weight, r_fin_valid && w_out_adv && r_fin_acc == '0, r_out_weight == '0)

endmodule

### tb/scale_weight_frame_decoder_core_tb.sv
// Self-checking testbench for the scale weight frame decoder core.
`timescale 1ns / 1ps

module scale_weight_frame_decoder_core_tb;
    import swfd_pkg::*;

    localparam int DIGITS        = DIGIT_COUNT_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 90;
    localparam int IDLE_LIMIT    = 4000;
    localparam longint unsigned WEIGHT_CAP = (64'd1 << WEIGHT_W) - 64'd1;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [CODE_W-1:0]   code;
    } weight_rec_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swfd_cfg_if cfg_ch ();
    swfd_in_if  in_ch ();
    swfd_out_if out_ch ();

    scale_weight_frame_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Frame tracker state, mirrored from what the block should hold.
    logic [FRAME_LEN_W-1:0] len_reg;
    bit                     framing;
    logic [FRAME_LEN_W-1:0] pos_count;
    logic [CODE_W-1:0]      code_reg;
    longint unsigned        digits_acc;

    weight_rec_t weights_due[$];
    int          mismatches;
    bit          calm;
    int          hold_requests;
    int          holds_served;
    int          stall_left;
    int          idle_cycles;

    function automatic longint unsigned pow_ten(input int e);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < e; i++) begin
            r = r * 10;
        end
        return r;
    endfunction

    function automatic void emit_weight();
        int              have;
        int              scale_exp;
        longint unsigned w;
        weight_rec_t     rec;
        have = (int'(pos_count) > FIRST_DIGIT_POS) ? int'(pos_count) - FIRST_DIGIT_POS : 0;
        if (have > DIGITS) begin
            have = DIGITS;
        end
        // Digits never received count as trailing zeros.
        scale_exp = (code_reg <= CODE_PLAIN_MAX) ? BASE_SHIFT
                                                 : int'(CODE_SHIFT_REF) - int'(code_reg);
        w = digits_acc * pow_ten(DIGITS - have) * pow_ten(scale_exp);
        if (w > WEIGHT_CAP) begin
            w = WEIGHT_CAP;
        end
        rec.weight = w[WEIGHT_W-1:0];
        rec.code   = code_reg;
        weights_due.push_back(rec);
        framing   = 1'b0;
        pos_count = '0;
    endfunction

    function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
        if (!framing) begin
            if (b != STX_BYTE) begin
                return;
            end
            framing    = 1'b1;
            pos_count  = 7'd1;
            code_reg   = '0;
            digits_acc = 0;
            if (len_reg <= 7'd1) begin
                emit_weight();
            end
            return;
        end
        if (pos_count == 7'd1) begin
            code_reg = b[CODE_W-1:0];
        end
        if (int'(pos_count) >= FIRST_DIGIT_POS && int'(pos_count) < FIRST_DIGIT_POS + DIGITS) begin
            digits_acc = digits_acc * 10 +
                         ((b >= ASCII_ZERO && b <= ASCII_NINE) ? (b - ASCII_ZERO) : 0);
        end
        if (pos_count < COUNT_MAX) begin
            pos_count = pos_count + 7'd1;
        end
        if (pos_count >= len_reg) begin
            emit_weight();
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        decode_rx_byte(b);
        @(negedge i_clk);
    endtask

    task automatic wait_weights_out();
        in_ch.valid <= 1'b0;
        while (weights_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_frame_length(input logic [FRAME_LEN_W-1:0] len);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.frame_length <= len;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        len_reg = len;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [BYTE_W-1:0] frame_byte(input int pos);
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        if (pos == 0) begin
            b = STX_BYTE;
        end else if (pos >= FIRST_DIGIT_POS && pos < FIRST_DIGIT_POS + DIGITS &&
                     $urandom_range(0, 6) != 0) begin
            b = ASCII_ZERO + BYTE_W'($urandom_range(0, 9));
        end
        return b;
    endfunction

    // Well-formed frames with random content, with line noise between them.
    task automatic run_frames(input int byte_budget);
        int sent;
        int span;
        sent = 0;
        span = (len_reg <= 7'd1) ? 1 : int'(len_reg);
        while (sent < byte_budget) begin
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end
            for (int pos = 0; pos < span; pos++) begin
                send_byte(frame_byte(pos));
            end
            sent += span;
            if ($urandom_range(0, 29) == 0) begin
                wait_weights_out();
            end
        end
    endtask

    task automatic run_phase(input logic [FRAME_LEN_W-1:0] len, input int byte_budget,
                             input bit quiet);
        wait_weights_out();
        write_frame_length(len);
        calm = quiet;
        run_frames(byte_budget);
    endtask

    task automatic test_reset_length_cut();
        // Ten bytes stay inside the reset length; cutting the length to ten
        // mid-frame makes the next byte close the frame.
        send_byte(STX_BYTE);
        send_byte(8'hF8);
        send_byte(STX_BYTE);
        send_byte(8'h80);
        repeat (DIGITS) send_byte(ASCII_NINE);
        wait_weights_out();
        write_frame_length(7'd10);
        send_byte(8'hFF);
        wait_weights_out();
    endtask

    task automatic test_stx_only_frames();
        write_frame_length(7'd0);
        send_byte(8'hFF);
        send_byte(STX_BYTE);
        send_byte(STX_BYTE);
        wait_weights_out();
        write_frame_length(7'd1);
        send_byte(STX_BYTE);
        wait_weights_out();
    endtask

    task automatic test_short_digit_field();
        // The frame ends after two digit positions, one of them not a digit.
        write_frame_length(7'd6);
        send_byte(STX_BYTE);
        send_byte(8'h07);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h2F);
        send_byte(ASCII_NINE);
        wait_weights_out();
    endtask

    task automatic test_output_backpressure();
        wait_weights_out();
        write_frame_length(7'd10);
        calm = 1'b1;
        hold_requests++;
        run_frames(60);
        wait_weights_out();
        write_frame_length(7'd0);
        hold_requests++;
        repeat (24) send_byte(STX_BYTE);
        wait_weights_out();
        calm = 1'b0;
    endtask

    task automatic test_random_frames();
        run_phase(7'd18, 500, 1'b0);
        run_phase(7'd10, 260, 1'b1);
        run_phase(7'd64, 200, 1'b0);
        repeat (5) run_phase(FRAME_LEN_W'($urandom_range(2, 20)), 40, 1'b0);
        run_phase(7'd0, 60, 1'b0);
        run_phase(7'd1, 40, 1'b0);
        run_phase(7'd127, 200, 1'b0);
    endtask

    task automatic test_quiet_tail();
        run_phase(7'd18, 300, 1'b1);
    endtask

    // Output ready: random stall bursts, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            stall_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 16);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        weight_rec_t due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (weights_due.size() == 0) begin
                $display("%0t: unexpected weight item: expected none, got weight %0d code %0d",
                         $time, out_ch.weight_scaled, out_ch.decimal_code);
                mismatches++;
            end else begin
                due = weights_due.pop_front();
                if (out_ch.weight_scaled !== due.weight) begin
                    $display("%0t: weight_scaled expected %0d, got %0d",
                             $time, due.weight, out_ch.weight_scaled);
                    mismatches++;
                end
                if (out_ch.decimal_code !== due.code) begin
                    $display("%0t: decimal_code expected %0d, got %0d",
                             $time, due.code, out_ch.decimal_code);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.rx_byte       = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.frame_length = '0;
        out_ch.ready        = 1'b0;
        len_reg             = FRAME_LEN_RESET;
        framing             = 1'b0;
        pos_count           = '0;
        code_reg            = '0;
        digits_acc          = 0;
        mismatches          = 0;
        calm                = 1'b0;
        hold_requests       = 0;
        holds_served        = 0;
        stall_left          = 0;
        idle_cycles         = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_reset_length_cut();
        test_stx_only_frames();
        test_short_digit_field();
        test_output_backpressure();
        test_random_frames();
        test_quiet_tail();

        wait_weights_out();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && weights_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### scale_weight_frame_decoder_core.f
+incdir+src
src/swfd_pkg.sv
src/swfd_channels_if.sv
src/scale_weight_frame_decoder_core.sv
tb/scale_weight_frame_decoder_core_tb.sv
